/* rtl/vec3_fast_normalize_macros.svh */
// Assertion macros for the vector normalizer RTL.
// No dependencies; included by the top-level module.
`ifndef VEC3_FAST_NORMALIZE_MACROS_SVH
`define VEC3_FAST_NORMALIZE_MACROS_SVH
`ifndef ASSERT_OFF
`define VFN_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define VFN_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define VFN_ASSERT(lbl, clk, rstn, prop, msg)
`define VFN_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

/* rtl/vfn_pkg.sv */
// Types, constants and float32 arithmetic functions for the vector normalizer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package vfn_pkg;

	localparam logic [31:0] MAGIC_EST = 32'h5f3759df;
	localparam logic [31:0] F_ONE_HALF = 32'h3FC00000;
	localparam logic [31:0] F_HALF = 32'h3F000000;
	localparam logic [31:0] CANON_NAN = 32'h7FC00000;
	localparam int NSTG = 13;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [31:0] s;
		logic [31:0] h;
		logic [31:0] r;
		logic [31:0] t0;
		logic [31:0] t1;
	} stage_t;

	// leading zeros of a 51-bit word, counted from bit 50
	function automatic logic [5:0] lzc51(input logic [50:0] m);
		logic [5:0] n;
		n = 6'd0;
		for (int i = 0; i < 51; i++)
			if (m[i]) n = 6'(50 - i);
		return n;
	endfunction

	// m has its leading one at bit 50; e is the biased exponent of that bit
	function automatic logic [31:0] round_pack(input logic sg, input logic signed [10:0] e,
			input logic [50:0] m);
		logic [5:0] sh;
		logic [7:0] ef;
		logic [50:0] mm;
		logic lost;
		logic up;
		logic [31:0] sum;
		if (m == 51'd0) return {sg, 31'd0};
		if (e >= 11'sd255) return {sg, 8'hFF, 23'd0};
		if (e < 11'sd1) begin
			sh = (e < -11'sd49) ? 6'd51 : 6'(11'sd1 - e);
			ef = 8'd0;
		end else begin
			sh = 6'd0;
			ef = e[7:0];
		end
		mm = m >> sh;
		lost = |(m & ~({51{1'b1}} << sh));
		up = mm[26] & ((|mm[25:0]) | lost | mm[27]);
		sum = {1'b0, ef, mm[49:27]} + 32'(up);
		return {sg, sum[30:0]};
	endfunction

	function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
		logic sg, nan_a, nan_b, inf_a, inf_b, zer_a, zer_b;
		logic [7:0] ea, eb;
		logic [23:0] ma, mb;
		logic [47:0] p;
		logic [50:0] pw;
		logic [5:0] lz;
		logic signed [10:0] e;
		sg = a[31] ^ b[31];
		nan_a = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
		nan_b = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
		inf_a = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
		inf_b = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
		zer_a = (a[30:0] == 31'd0);
		zer_b = (b[30:0] == 31'd0);
		if (nan_a || nan_b || (inf_a && zer_b) || (zer_a && inf_b)) return CANON_NAN;
		if (inf_a || inf_b) return {sg, 8'hFF, 23'd0};
		if (zer_a || zer_b) return {sg, 31'd0};
		ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
		eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
		ma = {a[30:23] != 8'd0, a[22:0]};
		mb = {b[30:23] != 8'd0, b[22:0]};
		p = ma * mb;
		pw = {p, 3'd0};
		lz = lzc51(pw);
		e = $signed({3'd0, ea}) + $signed({3'd0, eb}) - 11'sd126 - $signed({5'd0, lz});
		return round_pack(sg, e, pw << lz);
	endfunction

	function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
		logic nan_a, nan_b, inf_a, inf_b;
		logic [31:0] u, v;
		logic [7:0] eu, ev, d;
		logic [5:0] shd, lz;
		logic [50:0] ua, vb0, vb, sm;
		logic lostb;
		logic signed [10:0] e;
		nan_a = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
		nan_b = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
		inf_a = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
		inf_b = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
		if (nan_a || nan_b || (inf_a && inf_b && (a[31] != b[31]))) return CANON_NAN;
		if (inf_a) return a;
		if (inf_b) return b;
		if (b[30:0] > a[30:0]) begin
			u = b;
			v = a;
		end else begin
			u = a;
			v = b;
		end
		eu = (u[30:23] == 8'd0) ? 8'd1 : u[30:23];
		ev = (v[30:23] == 8'd0) ? 8'd1 : v[30:23];
		d = eu - ev;
		shd = (d > 8'd50) ? 6'd51 : d[5:0];
		ua = {1'b0, u[30:23] != 8'd0, u[22:0], 26'd0};
		vb0 = {1'b0, v[30:23] != 8'd0, v[22:0], 26'd0};
		vb = vb0 >> shd;
		lostb = |(vb0 & ~({51{1'b1}} << shd));
		vb[0] = vb[0] | lostb;
		sm = (u[31] == v[31]) ? (ua + vb) : (ua - vb);
		if (sm == 51'd0) return (u[31] == v[31]) ? {u[31], 31'd0} : 32'd0;
		lz = lzc51(sm);
		e = $signed({3'd0, eu}) + 11'sd1 - $signed({5'd0, lz});
		return round_pack(u[31], e, sm << lz);
	endfunction

endpackage
`default_nettype wire

/* rtl/vec3_fast_normalize.sv */
// Approximate length and unit vector of one float32 3-vector.
// Depends on vfn_pkg and vec3_fast_normalize_macros.svh.
//
// Channel  Dir  Handshake         Payload
// s_axis   in   tvalid / tready   tdata: comp_x, comp_y, comp_z (96 bits)
// m_axis   out  tvalid / tready   tdata: magnitude, unit_x, unit_y, unit_z (128 bits)
//
// 13 register stages, up to four float ops per stage; one word per cycle unless the output stalls.
// arst_n clears all stage valid bits; payload registers are not reset.
// The whole pipeline holds while the last stage has a word not taken.
`timescale 1ns / 1ps
`default_nettype none
`include "vec3_fast_normalize_macros.svh"
module vec3_fast_normalize
	import vfn_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [95:0] s_axis_tdata,   // comp_x, comp_y, comp_z
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	output logic [127:0] m_axis_tdata       // magnitude, unit_x, unit_y, unit_z
);

	stage_t data_sx [1:NSTG];
	stage_t nxt [1:NSTG];
	logic [NSTG:1] valid_sx;
	logic en;
	logic in_acc;
	logic drain;

	assign en = !valid_sx[NSTG] || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = valid_sx[NSTG];
	assign m_axis_tdata = {data_sx[NSTG].z, data_sx[NSTG].y, data_sx[NSTG].x,
		data_sx[NSTG].t0};
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign drain = m_axis_tvalid && m_axis_tready && !valid_sx[NSTG-1];

	always_comb begin
		nxt[1] = data_sx[1];
		for (int k = 2; k <= NSTG; k++) nxt[k] = data_sx[k-1];
		// squares
		nxt[1].x = s_axis_tdata[31:0];
		nxt[1].y = s_axis_tdata[63:32];
		nxt[1].z = s_axis_tdata[95:64];
		nxt[1].t0 = fmul(s_axis_tdata[31:0], s_axis_tdata[31:0]);
		nxt[1].t1 = fmul(s_axis_tdata[63:32], s_axis_tdata[63:32]);
		nxt[1].s = fmul(s_axis_tdata[95:64], s_axis_tdata[95:64]);
		nxt[2].t0 = fadd(data_sx[1].t0, data_sx[1].t1);
		nxt[3].s = fadd(data_sx[2].t0, data_sx[2].s);
		// half and bit-level estimate
		nxt[4].h = fmul(data_sx[3].s, F_HALF);
		nxt[4].r = MAGIC_EST - {1'b0, data_sx[3].s[31:1]};
		// two Newton steps
		for (int n = 0; n < 2; n++) begin
			nxt[5+4*n].t0 = fmul(data_sx[4+4*n].h, data_sx[4+4*n].r);
			nxt[6+4*n].t0 = fmul(data_sx[5+4*n].t0, data_sx[5+4*n].r);
			nxt[7+4*n].t0 = fadd(F_ONE_HALF, {~data_sx[6+4*n].t0[31], data_sx[6+4*n].t0[30:0]});
			nxt[8+4*n].r = fmul(data_sx[7+4*n].r, data_sx[7+4*n].t0);
		end
		nxt[13].t0 = fmul(data_sx[12].s, data_sx[12].r);
		nxt[13].x = fmul(data_sx[12].x, data_sx[12].r);
		nxt[13].y = fmul(data_sx[12].y, data_sx[12].r);
		nxt[13].z = fmul(data_sx[12].z, data_sx[12].r);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sx <= '0;
		end else if (en) begin
			valid_sx <= {valid_sx[NSTG-1:1], s_axis_tvalid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 1; k <= NSTG; k++) data_sx[k] <= nxt[k];
		end
	end

	`VFN_ASSERT_NEXT(a_enter, clk, arst_n, in_acc, valid_sx[1], "accepted word lost at stage 1")
	`VFN_ASSERT_NEXT(a_hold, clk, arst_n, !en, $stable(valid_sx), "pipeline moved during stall")
	`VFN_ASSERT_NEXT(a_drain, clk, arst_n, drain, !m_axis_tvalid, "result word repeated")

endmodule
`default_nettype wire
